// File: design/sha256_pkg.sv
// Shared constants and round functions for the SHA-256 byte-stream hasher.
package sha256_pkg;

  localparam int WordWidth = 32;
  localparam int BlockWords = 16;
  localparam int HashWords = 8;
  localparam int Rounds = 64;
  localparam int CountWidth = 61;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_const(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Status record with busy and done flags
  typedef struct packed {
    logic busy;
    logic done;
  } sha_core_stat_t;

endpackage

// File: design/sha_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module sha_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/sha_core.sv
// SHA-256 round datapath: schedule window and round registers, one round per cycle while round_en is high.
module sha_core (
  input  logic        clk,
  input  logic        load_en,
  input  logic [31:0] load_word,
  input  logic        h_wr,
  input  logic [2:0]  h_idx,
  input  logic [31:0] h_word,
  input  logic        round_en,
  input  logic [5:0]  t,
  input  logic [2:0]  rd_idx,
  output logic [31:0] r_word
);
  import sha256_pkg::*;

  logic [31:0] w [BlockWords];
  logic [31:0] r [HashWords];
  logic [31:0] w_new, s1, ch, t1, s0, maj, w15, w2;

  // Next schedule word from the window and the round terms
  always_comb begin
    w15 = w[1];
    w2 = w[14];
    w_new = w[0] + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3)) + w[9]
            + (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10));
    s1 = ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25);
    ch = (r[4] & r[5]) ^ (~r[4] & r[6]);
    t1 = r[7] + s1 + ch + round_const(t) + w[0];
    s0 = ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22);
    maj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
  end

  // Shift the window: load block words in order, or extend it during rounds
  always_ff @(posedge clk) begin
    if (load_en || round_en) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w[i] <= w[i+1];
      end
      w[BlockWords-1] <= load_en ? load_word : w_new;
    end
  end

  // Load the chaining words, or advance one round
  always_ff @(posedge clk) begin
    if (h_wr) begin
      r[h_idx] <= h_word;
    end else if (round_en) begin
      for (int i = 1; i < HashWords; i++) begin
        r[i] <= r[i-1];
      end
      r[4] <= r[3] + t1;
      r[0] <= t1 + s0 + maj;
    end
  end

  assign r_word = r[rd_idx];

endmodule

// File: design/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte-stream hasher.
//
// Channel | Handshake             | Fields
// input   | in_valid / in_stall   | data_byte, byte_present, end_of_message
// output  | out_valid / out_stall | digest_word, word_index, last_word
//
// A byte that does not fill the block is taken without a stall. The 64th byte of a block
// holds in_stall high while the block and chaining words are loaded, the 64 rounds run and
// the round registers are folded into the chaining-word RAM.
// An end item adds one padding byte per cycle up to the block end and hashes each padded
// block; the digest items follow, then a reload of the initial hash.
// Synchronous reset runs the same reload; in_stall stays high until it ends.
// out_stall holds the current digest item until taken.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PAD   = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [5:0]  step;
  logic [5:0]  step_prev;
  logic [5:0]  fill;
  logic [CountWidth-1:0] count;
  logic [23:0] acc;
  logic        ending;
  logic        padding;
  logic        tail_zero;
  logic        final_blk;
  logic [2:0]  out_idx;
  logic        rd_ok;

  logic        in_acc;
  logic [63:0] bits;
  logic        mark_now;
  logic        tail_z_now;
  logic [7:0]  pad_byte;
  logic [7:0]  byte_val;
  logic        byte_we;
  logic        msg_we;
  logic [31:0] msg_rd;
  logic        hash_we;
  logic [2:0]  hash_waddr;
  logic [2:0]  hash_raddr;
  logic [31:0] hash_wdata;
  logic [31:0] hash_rd;
  logic        load_en;
  logic        h_wr;
  logic        round_en;
  logic [31:0] r_word;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign bits = {count, 3'b000};
  assign step_prev = step - 6'd1;

  // Padding byte: the marker, then zeros, then the bit length in the last eight bytes
  always_comb begin
    mark_now = !padding;
    tail_z_now = tail_zero || (mark_now && fill >= 6'd56);
    if (mark_now) begin
      pad_byte = PadByte;
    end else if (tail_zero || fill < 6'd56) begin
      pad_byte = '0;
    end else begin
      pad_byte = bits[8*(7 - int'(fill[2:0])) +: 8];
    end
  end

  // Pack bytes big-endian; write a word once its fourth byte arrives
  assign byte_we = (state == S_PAD) || (in_acc && byte_present);
  assign byte_val = (state == S_PAD) ? pad_byte : data_byte;
  assign msg_we = byte_we && (fill[1:0] == 2'd3);

  sha_ram #(.Width(32), .Depth(BlockWords)) u_msg_ram (
    .clk     (clk),
    .wr_en   (msg_we),
    .wr_addr (fill[5:2]),
    .wr_data ({acc, byte_val}),
    .rd_addr (step[3:0]),
    .rd_data (msg_rd)
  );

  // Chaining words: initial values on reload, sums after each block
  always_comb begin
    hash_we = 1'b0;
    hash_waddr = step[2:0];
    hash_wdata = init_hash(step[2:0]);
    if (state == S_INIT) begin
      hash_we = 1'b1;
    end else if (state == S_UPD && step != 6'd0) begin
      hash_we = 1'b1;
      hash_waddr = step_prev[2:0];
      hash_wdata = hash_rd + r_word;
    end
  end

  assign hash_raddr = (state == S_OUT) ? out_idx : step[2:0];

  sha_ram #(.Width(32), .Depth(HashWords)) u_hash_ram (
    .clk     (clk),
    .wr_en   (hash_we),
    .wr_addr (hash_waddr),
    .wr_data (hash_wdata),
    .rd_addr (hash_raddr),
    .rd_data (hash_rd)
  );

  assign load_en = (state == S_LOAD) && (step != 6'd0);
  assign h_wr = load_en && (step <= 6'(HashWords));
  assign round_en = (state == S_ROUND);

  sha_core u_core (
    .clk       (clk),
    .load_en   (load_en),
    .load_word (msg_rd),
    .h_wr      (h_wr),
    .h_idx     (step_prev[2:0]),
    .h_word    (hash_rd),
    .round_en  (round_en),
    .t         (step),
    .rd_idx    (step_prev[2:0]),
    .r_word    (r_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      step <= '0;
      fill <= '0;
      count <= '0;
      acc <= '0;
      ending <= 1'b0;
      padding <= 1'b0;
      tail_zero <= 1'b0;
      final_blk <= 1'b0;
      out_idx <= '0;
      rd_ok <= 1'b0;
      out_valid <= 1'b0;
      digest_word <= '0;
      word_index <= '0;
      last_word <= 1'b0;
    end else begin
      // Advance the byte position
      if (byte_we) begin
        acc <= {acc[15:0], byte_val};
        fill <= fill + 6'd1;
      end
      case (state)
        S_INIT: begin
          if (step == 6'(HashWords - 1)) begin
            state <= S_IDLE;
            step <= '0;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (byte_present) begin
              count <= count + 1'b1;
            end
            ending <= end_of_message;
            if (byte_present && fill == 6'd63) begin
              state <= S_LOAD;
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          padding <= 1'b1;
          if (tail_z_now) begin
            tail_zero <= 1'b1;
          end
          if (fill == 6'd63) begin
            final_blk <= !tail_z_now;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (step == 6'(BlockWords)) begin
            state <= S_ROUND;
            step <= '0;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_ROUND: begin
          if (step == 6'(Rounds - 1)) begin
            state <= S_UPD;
            step <= '0;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_UPD: begin
          if (step == 6'(HashWords)) begin
            step <= '0;
            if (!ending) begin
              state <= S_IDLE;
            end else if (final_blk) begin
              state <= S_OUT;
            end else begin
              state <= S_PAD;
              tail_zero <= 1'b0;
            end
          end else begin
            step <= step + 6'd1;
          end
        end
        S_OUT: begin
          // Read one digest word, present it, hold it until taken
          if (!out_valid) begin
            if (rd_ok) begin
              out_valid <= 1'b1;
              digest_word <= hash_rd;
              word_index <= out_idx;
              last_word <= (out_idx == 3'(HashWords - 1));
            end else begin
              rd_ok <= 1'b1;
            end
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            rd_ok <= 1'b0;
            if (last_word) begin
              state <= S_INIT;
              count <= '0;
              ending <= 1'b0;
              padding <= 1'b0;
              tail_zero <= 1'b0;
              final_blk <= 1'b0;
              out_idx <= '0;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_INIT;
          step <= '0;
        end
      endcase
    end
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps

module tb;
  import sha256_pkg::*;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam int CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // Predictor state
  logic [31:0] chain_h[8];
  logic [31:0] block_w[16];
  logic [5:0]  fill_bytes;
  logic [60:0] msg_bytes;

  digest_item_t digest_queue[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit stall_quiet = 1'b0;

  sha256_byte_stream_hasher dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .byte_present(byte_present),
    .end_of_message(end_of_message), .out_valid(out_valid),
    .out_stall(out_stall), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] k_of(input int t);
    logic [31:0] ktab[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return ktab[t];
  endfunction

  task automatic clear_hash_state();
    chain_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    fill_bytes = '0;
    msg_bytes = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w[16];
    logic [31:0] r[8];
    logic [31:0] wt, g0, g1, s0, s1, ch, mj, t1;
    w = block_w;
    r = chain_h;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        g0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
        g1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
        wt = w[t&15] + g0 + w[(t-7)&15] + g1;
        w[t&15] = wt;
      end
      s1 = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
      ch = (r[4] & r[5]) ^ (~r[4] & r[6]);
      t1 = r[7] + s1 + ch + k_of(t) + wt;
      s0 = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
      mj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + s0 + mj;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += r[i];
  endtask

  task automatic pack_byte(input logic [7:0] b);
    int wi;
    int sh;
    wi = fill_bytes >> 2;
    sh = (3 - fill_bytes[1:0]) * 8;
    if (fill_bytes[1:0] == 2'd0) block_w[wi] = '0;
    block_w[wi] |= 32'(b) << sh;
    fill_bytes++;
    if (fill_bytes == 6'd0) compress_block();
  endtask

  // Predict the digest words caused by one accepted item
  task automatic predict_item(input logic [7:0] b, input logic pres, input logic eom);
    logic [63:0] bit_len;
    digest_item_t d;
    if (pres) begin
      pack_byte(b);
      msg_bytes++;
    end
    if (eom) begin
      bit_len = {msg_bytes, 3'b000};
      pack_byte(PadByte);
      while (fill_bytes != 6'd56) pack_byte(8'h00);
      for (int i = 0; i < 8; i++) pack_byte(bit_len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = chain_h[i];
        d.word_index = 3'(i);
        d.last_word = (i == 7);
        digest_queue.insert(digest_queue.size(), d);
      end
      clear_hash_state();
    end
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // Send one item, then, when gaps is set, a random gap before the next one
  task automatic send_item(input logic [7:0] b, input logic pres, input logic eom,
                           input bit gaps = 1'b1);
    int g;
    bit stalled;
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= pres;
    end_of_message <= eom;
    // Stall seen before each edge decides whether that edge takes the item
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    predict_item(b, pres, eom);
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len, input bit end_with_byte, input bit gaps);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, end_with_byte && (i == len - 1), gaps);
    if (!end_with_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1, gaps);
  endtask

  task automatic test_empty_message();
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_byte_extremes();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Bit length spilling into a second block, and a message that fills one block exactly
  task automatic test_padding_edges();
    send_message(56, 1'b1, 1'b0);
    send_message(64, 1'b1, 1'b0);
  endtask

  task automatic test_random_messages();
    int sent;
    int len;
    sent = 0;
    while (sent < 20) begin
      len = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_message(len, $urandom_range(0, 1), 1'b1);
      sent += len + 1;
    end
    stall_quiet = 1'b1;
    send_message(3, 1'b1, 1'b0);
  endtask

  // Random output stall, with quiet stretches
  always @(posedge clk) begin
    if (rst || stall_quiet) out_stall <= 1'b0;
    else if ($urandom_range(0, 39) == 0) out_stall <= 1'b1;
    else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
  end

  // Compare each accepted digest word with the oldest expectation
  always @(posedge clk) begin
    digest_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest word %h", digest_word);
        fail_count++;
      end else begin
        e = digest_queue.pop_front();
        if (digest_word !== e.digest_word) begin
          $error("digest_word: expected %h, got %h", e.digest_word, digest_word);
          fail_count++;
        end
        if (word_index !== e.word_index) begin
          $error("word_index: expected %0d, got %0d", e.word_index, word_index);
          fail_count++;
        end
        if (last_word !== e.last_word) begin
          $error("last_word: expected %0d, got %0d", e.last_word, last_word);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sha256_byte_stream_hasher: mismatch");
      $finish;
    end
  end

  initial begin
    clear_hash_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_byte_extremes();
    test_padding_edges();
    test_random_messages();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("sha256_byte_stream_hasher: match");
    else $display("sha256_byte_stream_hasher: mismatch");
    $finish;
  end

endmodule
